// ===== design/ill_pkg.sv =====
// Shared types and constants for the INI line lexer.
package ill_pkg;

    localparam int LINE_LEN_MAX_DEF     = 255;
    localparam int LINE_NUMBER_BITS_DEF = 16;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_US   = 8'h5F;
    localparam logic [7:0] CH_NL   = 8'h0A;

    localparam logic [3:0] TK_IGNORED  = 4'd0;
    localparam logic [3:0] TK_SECT_CH  = 4'd1;
    localparam logic [3:0] TK_SECT_END = 4'd2;
    localparam logic [3:0] TK_KEY_CH   = 4'd3;
    localparam logic [3:0] TK_KEY_END  = 4'd4;
    localparam logic [3:0] TK_VAL_CH   = 4'd5;
    localparam logic [3:0] TK_REC_END  = 4'd6;
    localparam logic [3:0] TK_ERROR    = 4'd7;
    localparam logic [3:0] TK_HALTED   = 4'd8;

    localparam logic [3:0] M_START = 4'd0;
    localparam logic [3:0] M_SECT  = 4'd1;
    localparam logic [3:0] M_KEY   = 4'd2;
    localparam logic [3:0] M_KSP   = 4'd3;
    localparam logic [3:0] M_VLEAD = 4'd4;
    localparam logic [3:0] M_VAL   = 4'd5;
    localparam logic [3:0] M_VCUT  = 4'd6;
    localparam logic [3:0] M_CUT   = 4'd7;
    localparam logic [3:0] M_HALT  = 4'd8;

    typedef struct packed {
        logic [7:0] data;
        logic       nl;
        logic       cut;
        logic       blank;
        logic       word;
        logic       lbr;
        logic       rbr;
        logic       eq;
    } ill_item_t;

endpackage

// ===== design/ill_front.sv =====
// Front end: accepts input beats, classifies bytes and tracks line position.
module ill_front
    import ill_pkg::*;
#(
    parameter int LINE_LEN_MAX = LINE_LEN_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic       q_full,
    output logic       push,
    output ill_item_t  item
);

    localparam int LP_W = $clog2(LINE_LEN_MAX + 1);

    logic [LP_W-1:0] line_pos_reg;
    logic [LP_W-1:0] line_pos_next;
    logic            long_line;

    function automatic logic blank_byte(input logic [7:0] b);
        blank_byte = (b == 8'd9) || (b == 8'd11) || (b == 8'd12) || (b == 8'd13)
                     || (b == 8'd32);
    endfunction

    function automatic logic word_byte(input logic [7:0] b);
        word_byte = (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]})
                    || (b == CH_US);
    endfunction

    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;
    assign long_line = line_pos_reg >= LP_W'(LINE_LEN_MAX);

    always_comb
    begin
        item.data     = data_byte;
        item.nl       = end_of_input || (data_byte == CH_NL);
        item.cut      = 1'b0;
        item.blank    = blank_byte(data_byte);
        item.word     = word_byte(data_byte);
        item.lbr      = data_byte == CH_LBR;
        item.rbr      = data_byte == CH_RBR;
        item.eq       = data_byte == CH_EQ;
        line_pos_next = line_pos_reg;
        if (item.nl)
        begin
            line_pos_next = '0;
        end
        else if (long_line)
        begin
            item.cut = 1'b1;
        end
        else
        begin
            line_pos_next = line_pos_reg + 1'b1;
            item.cut      = (data_byte == CH_HASH) || (data_byte == 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg <= '0;
        end
        else if (push)
        begin
            line_pos_reg <= line_pos_next;
        end
    end

endmodule

// ===== design/ill_queue.sv =====
// Short queue of classified bytes between front end and lexer.
module ill_queue
    import ill_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ill_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output ill_item_t q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ill_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = slot_reg[head_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
        end
    end

endmodule

// ===== design/ill_back.sv =====
// Back end: line lexer state machine and registered result beat.
module ill_back
    import ill_pkg::*;
#(
    parameter int LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  ill_item_t   q_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [7:0]  char_out,
    output logic [7:0]  field_position,
    output logic [7:0]  value_length,
    output logic [15:0] error_line
);

    localparam int LW = LINE_NUMBER_BITS;

    logic [3:0]    mode_reg, mode_next;
    logic          sv_reg, sv_next;
    logic [7:0]    ci_reg, ci_next;
    logic [7:0]    te_reg, te_next;
    logic [LW-1:0] line_reg, line_next;
    logic          out_valid_reg;

    logic [3:0]    kind_reg, kind_next;
    logic [7:0]    ch_reg, ch_next;
    logic [7:0]    pos_reg, pos_next;
    logic [7:0]    vlen_reg, vlen_next;
    logic [15:0]   eline_reg, eline_next;

    logic [LW+15:0] line_wide;
    logic [15:0]    line_sat;
    logic [7:0]     ci_inc;
    logic           err;
    logic           vchar;

    assign pop        = q_valid && (!out_valid_reg || !out_stall);
    assign line_wide  = {16'd0, line_reg};
    assign line_sat   = (line_wide > (LW + 16)'(16'hFFFF)) ? 16'hFFFF : line_wide[15:0];
    assign ci_inc     = (ci_reg == 8'hFF) ? 8'hFF : ci_reg + 8'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        sv_next    = sv_reg;
        ci_next    = ci_reg;
        te_next    = te_reg;
        line_next  = line_reg;
        kind_next  = TK_IGNORED;
        ch_next    = 8'd0;
        pos_next   = 8'd0;
        vlen_next  = 8'd0;
        eline_next = 16'd0;
        err        = 1'b0;
        vchar      = 1'b0;
        if (mode_reg == M_HALT)
        begin
            kind_next  = TK_HALTED;
            eline_next = line_sat;
        end
        else
        begin
            case (mode_reg)
                M_START:
                begin
                    if (q_item.nl || (q_item.blank && !q_item.cut))
                    begin
                    end
                    else if (q_item.cut)
                    begin
                        mode_next = M_CUT;
                    end
                    else if (q_item.lbr)
                    begin
                        mode_next = M_SECT;
                        ci_next   = 8'd0;
                    end
                    else if (q_item.word)
                    begin
                        if (!sv_reg)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            mode_next = M_KEY;
                            kind_next = TK_KEY_CH;
                            ch_next   = q_item.data;
                            ci_next   = 8'd1;
                        end
                    end
                    else
                    begin
                        mode_next = M_CUT;
                    end
                end
                M_SECT:
                begin
                    if (q_item.nl || q_item.cut)
                    begin
                        err = 1'b1;
                    end
                    else if (q_item.word)
                    begin
                        kind_next = TK_SECT_CH;
                        ch_next   = q_item.data;
                        pos_next  = ci_reg;
                        ci_next   = ci_inc;
                    end
                    else if (q_item.rbr)
                    begin
                        kind_next = TK_SECT_END;
                        pos_next  = ci_reg;
                        sv_next   = ci_reg != 8'd0;
                        mode_next = M_CUT;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                M_KEY:
                begin
                    if (q_item.nl || q_item.cut)
                    begin
                        err = 1'b1;
                    end
                    else if (q_item.word)
                    begin
                        kind_next = TK_KEY_CH;
                        ch_next   = q_item.data;
                        pos_next  = ci_reg;
                        ci_next   = ci_inc;
                    end
                    else if (q_item.blank || q_item.eq)
                    begin
                        kind_next = TK_KEY_END;
                        pos_next  = ci_reg;
                        if (q_item.eq)
                        begin
                            mode_next = M_VLEAD;
                            ci_next   = 8'd0;
                            te_next   = 8'd0;
                        end
                        else
                        begin
                            mode_next = M_KSP;
                        end
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                M_KSP:
                begin
                    if (q_item.nl || q_item.cut)
                    begin
                        err = 1'b1;
                    end
                    else if (q_item.eq)
                    begin
                        mode_next = M_VLEAD;
                        ci_next   = 8'd0;
                        te_next   = 8'd0;
                    end
                    else if (!q_item.blank)
                    begin
                        err = 1'b1;
                    end
                end
                M_VLEAD:
                begin
                    if (q_item.nl)
                    begin
                        kind_next = TK_REC_END;
                    end
                    else if (q_item.cut)
                    begin
                        mode_next = M_VCUT;
                    end
                    else if (!q_item.blank)
                    begin
                        mode_next = M_VAL;
                        vchar     = 1'b1;
                    end
                end
                M_VAL:
                begin
                    if (q_item.nl)
                    begin
                        kind_next = TK_REC_END;
                        vlen_next = te_reg;
                    end
                    else if (q_item.cut)
                    begin
                        mode_next = M_VCUT;
                    end
                    else
                    begin
                        vchar = 1'b1;
                    end
                end
                M_VCUT:
                begin
                    if (q_item.nl)
                    begin
                        kind_next = TK_REC_END;
                        vlen_next = te_reg;
                    end
                end
                default:
                begin
                end
            endcase

            if (vchar)
            begin
                kind_next = TK_VAL_CH;
                ch_next   = q_item.data;
                pos_next  = ci_reg;
                ci_next   = ci_inc;
                if (!q_item.blank)
                begin
                    te_next = ci_inc;
                end
            end

            if (err)
            begin
                kind_next  = TK_ERROR;
                ch_next    = 8'd0;
                pos_next   = 8'd0;
                vlen_next  = 8'd0;
                eline_next = line_sat;
                mode_next  = M_HALT;
            end
            else if (q_item.nl)
            begin
                if (line_reg != {LW{1'b1}})
                begin
                    line_next = line_reg + 1'b1;
                end
                mode_next = M_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_START;
            sv_reg        <= 1'b0;
            ci_reg        <= 8'd0;
            te_reg        <= 8'd0;
            line_reg      <= LW'(1);
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            mode_reg      <= mode_next;
            sv_reg        <= sv_next;
            ci_reg        <= ci_next;
            te_reg        <= te_next;
            line_reg      <= line_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            ch_reg    <= ch_next;
            pos_reg   <= pos_next;
            vlen_reg  <= vlen_next;
            eline_reg <= eline_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign token_kind     = kind_reg;
    assign char_out       = ch_reg;
    assign field_position = pos_reg;
    assign value_length   = vlen_reg;
    assign error_line     = eline_reg;

endmodule

// ===== design/ini_line_lexer.sv =====
// Top level of the INI line lexer: front end, queue and lexer back end.
// One byte enters per beat and one classified result beat leaves per input beat, in
// order. Sustained rate is one byte per cycle while out_stall is low: the front end
// classifies a byte and tracks its line position in the cycle it is accepted, a
// two-entry queue decouples it from the lexer state machine, which updates once per
// byte and loads a registered result beat. A byte passes a queue slot, then the result
// register. After an error every beat answers halted with the error line until reset.
module ini_line_lexer
    import ill_pkg::*;
#(
    parameter int LINE_LEN_MAX     = LINE_LEN_MAX_DEF,
    parameter int LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [7:0]  char_out,
    output logic [7:0]  field_position,
    output logic [7:0]  value_length,
    output logic [15:0] error_line
);

    logic      push;
    logic      q_full;
    logic      q_valid;
    logic      pop;
    ill_item_t push_item;
    ill_item_t q_item;

    ill_front #(
        .LINE_LEN_MAX (LINE_LEN_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .push         (push),
        .item         (push_item)
    );

    ill_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    ill_back #(
        .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .char_out       (char_out),
        .field_position (field_position),
        .value_length   (value_length),
        .error_line     (error_line)
    );

endmodule
